// ===== rtl/core/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg
// shared types and constants for the lru page store
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int unsigned MaxEntriesDefault = 512;
  localparam int unsigned KeyBitsDefault    = 40;
  localparam int unsigned FieldKeyW         = 40;
  localparam int unsigned CapW              = 10;
  localparam int unsigned CntW              = 32;
  localparam logic [CapW-1:0] CapReset      = 10'd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_UPDATE,
    ST_OUT
  } lru_state_e;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan_step;
    logic upd_step;
    logic commit;
  } lru_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic upd_done;
  } lru_sts_t;

endpackage

// ===== rtl/core/lru_ram.sv =====
// ----------------------------------------------------------------------------
// lru_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module lru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/lru_ctrl.sv =====
// ----------------------------------------------------------------------------
// lru_ctrl
// sequencer for lookup, rank update and result hand off
// ----------------------------------------------------------------------------
module lru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output lru_pkg::lru_cmd_t cmd_o,
  input  lru_pkg::lru_sts_t sts_i
);
  import lru_pkg::*;

  lru_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    cmd_o.clear = cfg_we_i;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.upd_step = 1'b1;
        if (sts_i.upd_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_OUT;
        end
      end
      ST_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          req_ready_o = 1'b1;
          if (req_valid_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/lru_dp.sv =====
// ----------------------------------------------------------------------------
// lru_dp
// key and rank stores, scan counters, hit and miss totals
// ----------------------------------------------------------------------------
module lru_dp #(
  parameter int unsigned MaxEntries = lru_pkg::MaxEntriesDefault,
  parameter int unsigned KeyBits    = lru_pkg::KeyBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lru_pkg::CapW-1:0]    cfg_wdata_i,
  input  logic [lru_pkg::FieldKeyW-1:0] page_key_i,
  input  lru_pkg::lru_cmd_t           cmd_i,
  output lru_pkg::lru_sts_t           sts_o,
  output logic                        was_hit_o,
  output logic                        did_evict_o,
  output logic [lru_pkg::FieldKeyW-1:0] evicted_key_o,
  output logic [lru_pkg::CntW-1:0]    hits_so_far_o,
  output logic [lru_pkg::CntW-1:0]    misses_so_far_o
);
  import lru_pkg::*;

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned OW = AW + 1;
  localparam int unsigned CmpW = (KeyBits < FieldKeyW) ? KeyBits : FieldKeyW;
  localparam int unsigned CapCmpW = (OW > CapW) ? OW : CapW;

  logic [OW-1:0]        cap_q, occ_q, occ_d;
  logic [CntW-1:0]      hit_q, miss_q;
  logic [CmpW-1:0]      key_q;
  logic [OW-1:0]        idx_q;      // issued read address
  logic                 rv_q;       // read data valid
  logic [AW-1:0]        ra_q;       // address of returning data
  logic                 found_q;
  logic [AW-1:0]        slot_q;
  logic [AW-1:0]        worst_slot_q;
  logic [AW-1:0]        worst_q;
  logic [AW-1:0]        hit_rank_q;
  logic [FieldKeyW-1:0] worst_key_q;
  logic                 evict_q;
  logic [AW-1:0]        limit_q;

  logic [CmpW-1:0]      key_rd;
  logic [AW-1:0]        rank_rd;
  logic                 key_we, rank_we;
  logic [AW-1:0]        key_wa, rank_wa, rd_addr;
  logic [AW-1:0]        rank_wd;
  logic [OW-1:0]        cap_clamp;
  logic                 full;

  lru_ram #(.Width(CmpW), .Depth(MaxEntries)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_q),
    .raddr_i(rd_addr), .rdata_o(key_rd)
  );

  lru_ram #(.Width(AW), .Depth(MaxEntries)) u_ranks (
    .clk_i, .we_i(rank_we), .waddr_i(rank_wa), .wdata_i(rank_wd),
    .raddr_i(rd_addr), .rdata_o(rank_rd)
  );

  always_comb begin
    cap_clamp = (cfg_wdata_i == '0) ? OW'(1) :
                (CapCmpW'(cfg_wdata_i) > CapCmpW'(MaxEntries)) ? OW'(MaxEntries) :
                OW'(cfg_wdata_i);
  end

  assign full       = (occ_q >= cap_q);
  assign rd_addr    = idx_q[AW-1:0];
  assign sts_o.scan_done = cmd_i.scan_step && (occ_q == '0 || idx_q >= occ_q);
  assign sts_o.upd_done  = cmd_i.upd_step && (occ_q == '0 || (!rv_q && idx_q >= occ_q));

  // key written at the commit on a miss, rank rewritten during the update sweep and zeroed at the commit
  assign key_we  = cmd_i.commit && !found_q;
  assign key_wa  = slot_q;
  assign rank_we = (cmd_i.upd_step && rv_q) || cmd_i.commit;
  assign rank_wa = cmd_i.commit ? slot_q : ra_q;
  assign rank_wd = cmd_i.commit ? '0 :
                   (rank_rd < limit_q) ? rank_rd + AW'(1) : rank_rd;

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.commit && !found_q && !full) occ_d = occ_q + OW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= OW'(CapReset > MaxEntries ? MaxEntries : CapReset);
      occ_q  <= '0;
      hit_q  <= '0;
      miss_q <= '0;
      rv_q   <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_i.clear) begin
      cap_q  <= cap_clamp;
      occ_q  <= '0;
      hit_q  <= '0;
      miss_q <= '0;
      rv_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.start) begin
        idx_q <= '0;
        rv_q  <= 1'b0;
      end else if (cmd_i.scan_step || cmd_i.upd_step) begin
        rv_q <= !found_q && cmd_i.scan_step ? (idx_q < occ_q) :
                cmd_i.upd_step ? (idx_q < occ_q) : 1'b0;
        if (idx_q < occ_q) idx_q <= idx_q + OW'(1);
        if (sts_o.scan_done) idx_q <= '0;
      end else begin
        rv_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (found_q && hit_q != '1) hit_q <= hit_q + 1'b1;
        if (!found_q && miss_q != '1) miss_q <= miss_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= rd_addr;
    if (cmd_i.start) begin
      key_q   <= page_key_i[CmpW-1:0];
      found_q <= 1'b0;
      worst_q <= '0;
      worst_slot_q <= '0;
    end
    if (rv_q && !cmd_i.upd_step && !found_q) begin
      if (key_rd == key_q) begin
        found_q    <= 1'b1;
        slot_q     <= ra_q;
        hit_rank_q <= rank_rd;
      end
      if (rank_rd >= worst_q) begin
        worst_q      <= rank_rd;
        worst_slot_q <= ra_q;
        worst_key_q  <= FieldKeyW'(key_rd);
      end
    end
    if (!cmd_i.scan_step && !cmd_i.upd_step && !cmd_i.commit && !cmd_i.start) begin
      if (found_q) begin
        limit_q <= hit_rank_q;
        evict_q <= 1'b0;
      end else if (!full) begin
        limit_q <= occ_q[AW-1:0];
        slot_q  <= occ_q[AW-1:0];
        evict_q <= 1'b0;
      end else begin
        limit_q <= worst_q;
        slot_q  <= worst_slot_q;
        evict_q <= 1'b1;
      end
    end
    if (cmd_i.commit) begin
      was_hit_o       <= found_q;
      did_evict_o     <= evict_q;
      evicted_key_o   <= evict_q ? worst_key_q : '0;
      hits_so_far_o   <= (found_q && hit_q != '1) ? hit_q + 1'b1 : hit_q;
      misses_so_far_o <= (!found_q && miss_q != '1) ? miss_q + 1'b1 : miss_q;
    end
  end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative page store with least recently used replacement
// ----------------------------------------------------------------------------
// a request carries one page key on page_key_i under req_valid_i/req_ready_o.
// the store scans every occupied entry once for the key and the oldest rank,
// then sweeps the rank memory once to age entries, set by the single read
// port of the key and rank memories. one request is worked on at a time.
// rsp_valid_o rises once the scan and the rank sweep are done, and the next
// request is taken in the cycle the result is. the result (hit, eviction,
// evicted key, hit and miss totals) is held on its output ports with
// rsp_valid_o until rsp_ready_i; while the receiver stalls no new request
// is taken. reset empties the store, zeroes the totals and sets the
// capacity to 512 or MaxEntries, whichever is smaller. writing
// cfg_we_i/cfg_wdata_i sets the capacity and empties the store; write only
// while idle. no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int unsigned MaxEntries = lru_pkg::MaxEntriesDefault,
  parameter int unsigned KeyBits    = lru_pkg::KeyBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lru_pkg::CapW-1:0]      cfg_wdata_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [lru_pkg::FieldKeyW-1:0] page_key_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          was_hit_o,
  output logic                          did_evict_o,
  output logic [lru_pkg::FieldKeyW-1:0] evicted_key_o,
  output logic [lru_pkg::CntW-1:0]      hits_so_far_o,
  output logic [lru_pkg::CntW-1:0]      misses_so_far_o
);
  import lru_pkg::*;

  lru_cmd_t cmd;
  lru_sts_t sts;

  lru_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .req_valid_i, .req_ready_o,
    .rsp_valid_o, .rsp_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  lru_dp #(.MaxEntries(MaxEntries), .KeyBits(KeyBits)) u_dp (
    .clk_i, .rst_ni, .cfg_wdata_i, .page_key_i,
    .cmd_i(cmd), .sts_o(sts), .was_hit_o, .did_evict_o, .evicted_key_o,
    .hits_so_far_o, .misses_so_far_o
  );

endmodule
